### rtl/core/adb_pkg.sv
// shared widths, constants, register codes and payload types for the dc blocker packetizer
package adb_pkg;

    localparam int RAW_W           = 12;
    localparam int SAMPLE_W        = 16;
    localparam int SEQ_W           = 32;
    localparam int INDEX_W         = 12;
    localparam int COEFF_W         = 15;
    localparam int LEN_W           = 13;
    localparam int ACC_W           = 40;
    localparam int COEFF_FRAC_BITS = 15;
    localparam int CENTER_SHIFT    = 4;
    localparam int DIFF_W          = SAMPLE_W + 1;
    localparam int PROD_W          = COEFF_W + 1 + ACC_W;

    localparam int MAX_PACKET_SAMPLES = 4096;

    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;
    localparam int REG_INDEX_LSB = 2;

    localparam logic [RAW_W-1:0]   RAW_MIDSCALE       = RAW_W'(2048);
    localparam logic [COEFF_W-1:0] POLE_COEFF_RESET   = COEFF_W'(32604);
    localparam logic [LEN_W-1:0]   PACKET_LEN_RESET   = LEN_W'(256);
    localparam logic [LEN_W-1:0]   PACKET_LEN_MAX     = LEN_W'(MAX_PACKET_SAMPLES);

    typedef enum logic [0:0] {
        REG_POLE_COEFF         = 1'b0,
        REG_SAMPLES_PER_PACKET = 1'b1
    } adb_reg_t;

    typedef struct packed {
        logic [COEFF_W-1:0] pole_coeff;
        logic [LEN_W-1:0]   samples_per_packet;
    } adb_cfg_t;

    typedef struct packed {
        logic [RAW_W-1:0] raw_sample;
    } adb_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] filtered_sample;
        logic [SEQ_W-1:0]           packet_seq;
        logic [INDEX_W-1:0]         sample_index;
        logic                       last_in_packet;
    } adb_out_t;

endpackage

### rtl/core/adb_stream_if.sv
// valid/ready stream interface carrying one payload item per transfer
interface adb_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );

endinterface

### rtl/core/adb_apb_regs.sv
// apb configuration registers: pole coefficient and packet length
module adb_apb_regs
    import adb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output adb_cfg_t              cfg
);

    adb_cfg_t cfg_reg;
    adb_cfg_t cfg_next;
    adb_reg_t reg_sel;
    logic     wr_en;

    assign reg_sel = adb_reg_t'(paddr[REG_INDEX_LSB]);
    assign wr_en   = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                REG_POLE_COEFF:         cfg_next.pole_coeff = pwdata[COEFF_W-1:0];
                REG_SAMPLES_PER_PACKET: cfg_next.samples_per_packet = pwdata[LEN_W-1:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_POLE_COEFF:         prdata = APB_DATA_W'(cfg_reg.pole_coeff);
            REG_SAMPLES_PER_PACKET: prdata = APB_DATA_W'(cfg_reg.samples_per_packet);
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pole_coeff         <= POLE_COEFF_RESET;
            cfg_reg.samples_per_packet <= PACKET_LEN_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/core/adb_dc_filter.sv
// centring and single-pole dc blocker with its feedback state
module adb_dc_filter
    import adb_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic [RAW_W-1:0]           raw_sample,
    input  logic [COEFF_W-1:0]         pole_coeff,
    output logic signed [SAMPLE_W-1:0] filtered_sample
);

    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (COEFF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0]  FRAC_MASK  = (ACC_W'(1) <<< COEFF_FRAC_BITS) - ACC_W'(1);
    localparam logic signed [SAMPLE_W-1:0] SAT_POS  = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAT_NEG  = {1'b1, {(SAMPLE_W-1){1'b0}}};

    logic signed [SAMPLE_W-1:0] prev_in_reg;
    logic signed [SAMPLE_W-1:0] prev_in_next;
    logic signed [ACC_W-1:0]    prev_out_reg;
    logic signed [ACC_W-1:0]    prev_out_next;

    logic [RAW_W-1:0]           centred;
    logic signed [SAMPLE_W-1:0] x;
    logic signed [DIFF_W-1:0]   dx;
    logic signed [ACC_W-1:0]    dx_scaled;
    logic signed [PROD_W-1:0]   product;
    logic signed [PROD_W-1:0]   product_rnd;
    logic signed [ACC_W-1:0]    feedback;
    logic signed [ACC_W-1:0]    y;
    logic signed [ACC_W-1:0]    y_biased;
    logic signed [ACC_W-1:0]    whole;
    logic                       in_range;

    // raw minus mid-scale, then shifted left by four bits into the sample width
    assign centred = raw_sample - RAW_MIDSCALE;
    assign x       = $signed({centred, {CENTER_SHIFT{1'b0}}});

    assign dx        = DIFF_W'(x) - DIFF_W'(prev_in_reg);
    assign dx_scaled = ACC_W'(dx) <<< COEFF_FRAC_BITS;

    // r * y_prev rounded to nearest, ties upward, kept modulo the accumulator width
    assign product     = $signed({1'b0, pole_coeff}) * prev_out_reg;
    assign product_rnd = product + ROUND_HALF;
    assign feedback    = product_rnd[COEFF_FRAC_BITS +: ACC_W];

    assign y = dx_scaled + feedback;

    // integer part truncated towards zero
    assign y_biased = y + (y[ACC_W-1] ? FRAC_MASK : ACC_W'(0));
    assign whole    = y_biased >>> COEFF_FRAC_BITS;

    assign in_range = (whole[ACC_W-1:SAMPLE_W-1] == '0) || (whole[ACC_W-1:SAMPLE_W-1] == '1);

    always_comb
    begin
        if (in_range)
            filtered_sample = whole[SAMPLE_W-1:0];
        else if (whole[ACC_W-1])
            filtered_sample = SAT_NEG;
        else
            filtered_sample = SAT_POS;
    end

    assign prev_in_next  = advance ? x : prev_in_reg;
    assign prev_out_next = advance ? y : prev_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_in_reg  <= '0;
            prev_out_reg <= '0;
        end
        else
        begin
            prev_in_reg  <= prev_in_next;
            prev_out_reg <= prev_out_next;
        end
    end

endmodule

### rtl/core/adb_packet_tagger.sv
// packet sequence number, sample position and last-of-packet mark
module adb_packet_tagger
    import adb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic [LEN_W-1:0]   samples_per_packet,
    output logic [SEQ_W-1:0]   packet_seq,
    output logic [INDEX_W-1:0] sample_index,
    output logic               last_in_packet
);

    logic [SEQ_W-1:0]   seq_reg;
    logic [SEQ_W-1:0]   seq_next;
    logic [INDEX_W-1:0] pos_reg;
    logic [INDEX_W-1:0] pos_next;
    logic [LEN_W-1:0]   len_eff;
    logic [LEN_W-1:0]   pos_plus_one;

    // zero length behaves as one, oversize clamps to the maximum
    always_comb
    begin
        if (samples_per_packet == '0)
            len_eff = LEN_W'(1);
        else if (samples_per_packet > PACKET_LEN_MAX)
            len_eff = PACKET_LEN_MAX;
        else
            len_eff = samples_per_packet;
    end

    assign pos_plus_one   = LEN_W'(pos_reg) + LEN_W'(1);
    assign last_in_packet = (pos_plus_one >= len_eff);
    assign packet_seq     = seq_reg;
    assign sample_index   = pos_reg;

    always_comb
    begin
        seq_next = seq_reg;
        pos_next = pos_reg;
        if (advance)
        begin
            if (last_in_packet)
            begin
                pos_next = '0;
                seq_next = seq_reg + SEQ_W'(1);
            end
            else
            begin
                pos_next = pos_plus_one[INDEX_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg <= '0;
            pos_reg <= '0;
        end
        else
        begin
            seq_reg <= seq_next;
            pos_reg <= pos_next;
        end
    end

endmodule

### rtl/core/adc_dc_block_packetizer.sv
// top level: adc dc blocking filter with packet tagging
// One result per 12-bit ADC sample, one sample per clock sustained while the result output
// is not stalled. A sample is captured in an input register; when the result register is
// free or being emptied, the filtered value and its packet tags are computed and loaded
// into the result register. The sustained rate is set by the feedback loop y_prev ->
// (15x40 multiply, round, add) -> y_prev, which closes through a single register.
// Either register absorbs a stall, so a new sample is taken while a finished result waits.
// Configuration must be written over the APB port only while idle; the block does not check.
module adc_dc_block_packetizer
    import adb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    adb_stream_if.sink            sample_in,
    adb_stream_if.source          result_out
);

    adb_cfg_t cfg;

    logic             in_valid_reg;
    logic             in_valid_next;
    logic [RAW_W-1:0] in_raw_reg;
    logic [RAW_W-1:0] in_raw_next;
    logic             res_valid_reg;
    logic             res_valid_next;
    adb_out_t         res_reg;
    adb_out_t         res_next;

    logic in_take;
    logic advance;

    logic signed [SAMPLE_W-1:0] filtered;
    logic [SEQ_W-1:0]           seq;
    logic [INDEX_W-1:0]         index;
    logic                       last;

    assign pready = 1'b1;

    adb_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // held sample moves on when the result register is free or being emptied
    assign advance         = in_valid_reg && (!res_valid_reg || result_out.ready);
    assign sample_in.ready = !in_valid_reg || advance;
    assign in_take         = sample_in.valid && sample_in.ready;

    adb_dc_filter u_filter (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (advance),
        .raw_sample      (in_raw_reg),
        .pole_coeff      (cfg.pole_coeff),
        .filtered_sample (filtered)
    );

    adb_packet_tagger u_tagger (
        .clk                (clk),
        .rst_n              (rst_n),
        .advance            (advance),
        .samples_per_packet (cfg.samples_per_packet),
        .packet_seq         (seq),
        .sample_index       (index),
        .last_in_packet     (last)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_raw_next   = in_raw_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
            in_raw_next   = sample_in.payload.raw_sample;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (advance)
        begin
            res_valid_next          = 1'b1;
            res_next.filtered_sample = filtered;
            res_next.packet_seq      = seq;
            res_next.sample_index    = index;
            res_next.last_in_packet  = last;
        end
        else if (result_out.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_raw_reg <= in_raw_next;
        res_reg    <= res_next;
    end

    assign result_out.valid   = res_valid_reg;
    assign result_out.payload = res_reg;

endmodule

### rtl/core/adb_checker.sv
// port-level checks on result ordering and packet tags, bound to the top level
module adb_checker
    import adb_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic signed [SAMPLE_W-1:0] out_sample,
    input logic [SEQ_W-1:0]           out_seq,
    input logic [INDEX_W-1:0]         out_index,
    input logic                       out_last
);

    logic               out_take;
    logic               seen_reg;
    logic               prev_last_reg;
    logic [SEQ_W-1:0]   prev_seq_reg;
    logic [INDEX_W-1:0] prev_index_reg;

    assign out_take = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg       <= 1'b0;
            prev_last_reg  <= 1'b0;
            prev_seq_reg   <= '0;
            prev_index_reg <= '0;
        end
        else if (out_take)
        begin
            seen_reg       <= 1'b1;
            prev_last_reg  <= out_last;
            prev_seq_reg   <= out_seq;
            prev_index_reg <= out_index;
        end
    end

    // a stalled result stays put
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(out_seq)
            && $stable(out_index) && $stable(out_last))
        else $error("result changed while stalled");

    a_first_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && !seen_reg |-> out_index == '0 && out_seq == '0)
        else $error("first result after reset not at packet zero, index zero");

    a_new_packet: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && seen_reg && prev_last_reg
            |-> out_index == '0 && out_seq == SEQ_W'(prev_seq_reg + SEQ_W'(1)))
        else $error("packet did not restart after last sample");

    a_same_packet: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && seen_reg && !prev_last_reg
            |-> out_index == INDEX_W'(prev_index_reg + INDEX_W'(1)) && out_seq == prev_seq_reg)
        else $error("sample index or sequence broke within a packet");

endmodule

bind adc_dc_block_packetizer adb_checker u_adb_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (result_out.valid),
    .out_ready  (result_out.ready),
    .out_sample (result_out.payload.filtered_sample),
    .out_seq    (result_out.payload.packet_seq),
    .out_index  (result_out.payload.sample_index),
    .out_last   (result_out.payload.last_in_packet)
);

### verif/adb_result_checker.sv
// checker for the dc blocker packetizer: mirrors register writes, predicts and compares results
module adb_result_checker
    import adb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  adb_in_t               in_item,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  adb_out_t              out_item,
    output int                    fail_count,
    output int                    pending,
    output int                    checked
);

    localparam longint UNITY    = longint'(1) << COEFF_FRAC_BITS;
    localparam longint HALF_LSB = UNITY >> 1;
    localparam longint SAT_HI   = 32767;
    localparam longint SAT_LO   = -32768;

    logic [COEFF_W-1:0] coeff;
    logic [LEN_W-1:0]   pkt_len;
    longint             x_prev;
    longint             y_prev;
    logic [SEQ_W-1:0]   seq;
    int unsigned        position;
    int                 fails;
    int                 compared;
    adb_out_t           expected_results[$];

    // one filter step plus packet tagging, advancing the mirrored state
    function automatic adb_out_t filter_and_tag(input logic [RAW_W-1:0] raw);
        longint                  x;
        longint                  feedback;
        longint                  y;
        longint                  whole;
        logic signed [ACC_W-1:0] y_acc;
        int unsigned             len;
        adb_out_t                res;
        x = (longint'(raw) - longint'(RAW_MIDSCALE)) * (longint'(1) << CENTER_SHIFT);
        // arithmetic shift gives the floor, so adding half first rounds ties upwards
        feedback = (longint'(coeff) * y_prev + HALF_LSB) >>> COEFF_FRAC_BITS;
        y_acc = ACC_W'((x - x_prev) * UNITY + feedback);
        y = longint'(y_acc);
        x_prev = x;
        y_prev = y;
        whole = (y < 0) ? -((-y) >>> COEFF_FRAC_BITS) : (y >>> COEFF_FRAC_BITS);
        if (whole > SAT_HI)
            whole = SAT_HI;
        else if (whole < SAT_LO)
            whole = SAT_LO;
        if (pkt_len == '0)
            len = 1;
        else if (pkt_len > PACKET_LEN_MAX)
            len = MAX_PACKET_SAMPLES;
        else
            len = pkt_len;
        res.filtered_sample = SAMPLE_W'(whole);
        res.packet_seq      = seq;
        res.sample_index    = INDEX_W'(position);
        // a length shrunk below the current position closes the packet at once
        res.last_in_packet  = (position + 1 >= len);
        if (res.last_in_packet)
        begin
            position = 0;
            seq      = seq + 1'b1;
        end
        else
        begin
            position = position + 1;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        adb_out_t want;
        if (!rst_n)
        begin
            coeff    = POLE_COEFF_RESET;
            pkt_len  = PACKET_LEN_RESET;
            x_prev   = 0;
            y_prev   = 0;
            seq      = '0;
            position = 0;
            fails    = 0;
            compared = 0;
            expected_results.delete();
            fail_count <= 0;
            pending    <= 0;
            checked    <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[APB_ADDR_W-1:REG_INDEX_LSB] == REG_POLE_COEFF)
                    coeff = pwdata[COEFF_W-1:0];
                else if (paddr[APB_ADDR_W-1:REG_INDEX_LSB] == REG_SAMPLES_PER_PACKET)
                    pkt_len = pwdata[LEN_W-1:0];
            end

            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with no sample outstanding: %p", out_item);
                    fails++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    compared++;
                    if (out_item.filtered_sample !== want.filtered_sample)
                    begin
                        $error("filtered_sample: expected %0d, got %0d",
                               want.filtered_sample, out_item.filtered_sample);
                        fails++;
                    end
                    if (out_item.packet_seq !== want.packet_seq)
                    begin
                        $error("packet_seq: expected %0d, got %0d",
                               want.packet_seq, out_item.packet_seq);
                        fails++;
                    end
                    if (out_item.sample_index !== want.sample_index)
                    begin
                        $error("sample_index: expected %0d, got %0d",
                               want.sample_index, out_item.sample_index);
                        fails++;
                    end
                    if (out_item.last_in_packet !== want.last_in_packet)
                    begin
                        $error("last_in_packet: expected %0d, got %0d",
                               want.last_in_packet, out_item.last_in_packet);
                        fails++;
                    end
                end
            end

            if (in_valid && in_ready)
                expected_results.push_back(filter_and_tag(in_item.raw_sample));

            fail_count <= fails;
            pending    <= expected_results.size();
            checked    <= compared;
        end
    end

endmodule

### verif/tb_top.sv
// testbench top: clock, reset, register set-up, sample traffic, result stalls and verdict
module tb_top
    import adb_pkg::*;
();

    localparam int RANDOM_PHASES    = 8;
    localparam int PHASE_SAMPLES    = 120;
    localparam int FULL_PACKET_RUN  = 120;
    localparam int LONG_HOLD        = 300;
    localparam int STALL_LIMIT      = 5000;
    localparam int DRAIN_CYCLES     = 8;
    localparam logic [RAW_W-1:0] RAW_MAX = {RAW_W{1'b1}};

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    int                    fail_count;
    int                    pending;
    int                    checked;
    int                    sent;
    int                    reg_writes;
    int                    dc_level;
    logic                  hold_request;

    adb_stream_if #(.payload_t(adb_in_t))  sample_ch ();
    adb_stream_if #(.payload_t(adb_out_t)) result_ch ();

    adc_dc_block_packetizer i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .sample_in  (sample_ch),
        .result_out (result_ch)
    );

    adb_result_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .in_valid   (sample_ch.valid),
        .in_ready   (sample_ch.ready),
        .in_item    (sample_ch.payload),
        .out_valid  (result_ch.valid),
        .out_ready  (result_ch.ready),
        .out_item   (result_ch.payload),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [RAW_W-1:0] pick_raw();
        int level;
        case ($urandom_range(0, 7))
            0:
                return $urandom_range(0, 1) ? RAW_MAX : '0;
            1, 2:
            begin
                // small signal riding on a dc offset
                level = dc_level + int'($urandom_range(0, 64)) - 32;
                if (level < 0)
                    level = 0;
                if (level > int'(RAW_MAX))
                    level = RAW_MAX;
                return RAW_W'(level);
            end
            default:
                return RAW_W'($urandom);
        endcase
    endfunction

    function automatic int pick_coeff();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 32767;
            2:       return POLE_COEFF_RESET;
            default: return $urandom_range(0, 32767);
        endcase
    endfunction

    function automatic int pick_len();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 1;
            2:       return $urandom_range(MAX_PACKET_SAMPLES + 1, 8191);
            3:       return $urandom_range(25, 300);
            default: return $urandom_range(2, 24);
        endcase
    endfunction

    // holds the sample until the transfer happens
    task automatic push_sample(input logic [RAW_W-1:0] raw);
        sample_ch.valid   <= 1'b1;
        sample_ch.payload <= '{raw_sample: raw};
        do
            @(posedge clk);
        while (sample_ch.ready !== 1'b1);
        sent++;
    endtask

    task automatic end_burst();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_traffic(input int count, input int max_gap);
        int left;
        int burst;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 24);
            if (burst > left)
                burst = left;
            repeat (burst)
                push_sample(pick_raw());
            left -= burst;
            if (left > 0 && max_gap > 0 && $urandom_range(0, 2) != 0)
            begin
                sample_ch.valid <= 1'b0;
                repeat ($urandom_range(1, max_gap))
                    @(posedge clk);
            end
        end
        end_burst();
    endtask

    task automatic wait_drained();
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic reg_write(input adb_reg_t which, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(which) << REG_INDEX_LSB;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        reg_writes++;
    endtask

    // unused upper data bits carry junk, the register must ignore them
    task automatic configure(input int coeff, input int len);
        wait_drained();
        reg_write(REG_POLE_COEFF, ($urandom << COEFF_W) | APB_DATA_W'(coeff));
        reg_write(REG_SAMPLES_PER_PACKET, ($urandom << LEN_W) | APB_DATA_W'(len));
    endtask

    // receiver: segments of differing stall patterns, plus one long hold-off on request
    initial
    begin
        int mode;
        int seg_len;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_request)
            begin
                @(posedge clk);
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD - 1)
                    @(posedge clk);
                hold_request = 1'b0;
            end
            mode    = $urandom_range(0, 3);
            seg_len = $urandom_range(10, 80);
            for (int i = 0; i < seg_len; i++)
            begin
                @(posedge clk);
                case (mode)
                    0:       result_ch.ready <= 1'b1;
                    1:       result_ch.ready <= $urandom_range(0, 1);
                    2:       result_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: result_ch.ready <= i[0];
                endcase
            end
        end
    end

    // watchdog on cycles without any transfer or register access
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
                || psel)
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, pending);
        $display("[adc_dc_block_packetizer] ERROR");
        $finish;
    end

    initial
    begin
        logic [RAW_W-1:0] corner_vals [11];
        corner_vals       = '{12'd2048, 12'd2048, 12'd0, RAW_MAX, RAW_MAX,
                              12'd0, 12'd2047, 12'd2049, 12'd1, 12'hAAA,
                              12'h555};
        rst_n             <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        sample_ch.valid   <= 1'b0;
        sample_ch.payload <= '0;
        hold_request      = 1'b0;
        sent              = 0;
        reg_writes        = 0;
        dc_level          = 2048;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: midscale, full-scale steps into saturation both ways
        foreach (corner_vals[i])
            push_sample(corner_vals[i]);
        end_burst();

        // zero length behaves as one sample per packet, coefficient at its top
        configure(32767, 0);
        push_sample(RAW_MAX);
        push_sample('0);
        push_sample(RAW_MAX);
        end_burst();

        // no feedback at all
        configure(0, 3);
        push_sample('0);
        push_sample(RAW_MAX);
        push_sample(12'd2048);
        push_sample(12'd1);
        end_burst();

        // shrinking the length below the current position ends the packet at once
        configure(POLE_COEFF_RESET, 8191);
        repeat (5)
            push_sample(pick_raw());
        end_burst();
        configure(POLE_COEFF_RESET, 2);
        push_sample(RAW_MAX);
        push_sample('0);
        end_burst();

        // a long run with an oversize length that clamps to the maximum
        configure(pick_coeff(), 8191);
        run_traffic(FULL_PACKET_RUN, 2);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            configure(pick_coeff(), pick_len());
            dc_level = $urandom_range(0, RAW_MAX);
            if (phase == 2)
                hold_request = 1'b1;
            if (phase == 5)
            begin
                // sender stops until every result is back, then resumes
                run_traffic(PHASE_SAMPLES / 2, 4);
                wait_drained();
                run_traffic(PHASE_SAMPLES - PHASE_SAMPLES / 2, 4);
            end
            else
            begin
                run_traffic(PHASE_SAMPLES, (phase % 3 == 0) ? 0 : $urandom_range(1, 6));
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("run covered %0d samples and %0d checked results over %0d register writes,",
                 sent, checked, reg_writes);
        $display("with coefficient and packet length extremes, a long result stall and clamping");
        if (fail_count == 0 && pending == 0)
            $display("[adc_dc_block_packetizer] OK");
        else
            $display("[adc_dc_block_packetizer] ERROR");
        $finish;
    end

endmodule

### filelist.f
rtl/core/adb_pkg.sv
rtl/core/adb_stream_if.sv
rtl/core/adb_apb_regs.sv
rtl/core/adb_dc_filter.sv
rtl/core/adb_packet_tagger.sv
rtl/core/adc_dc_block_packetizer.sv
rtl/core/adb_checker.sv
verif/adb_result_checker.sv
verif/tb_top.sv
